/* design/hspf_pkg.sv */
// Shared types, octet constants and CRC helper for the HDLC-style packet framer.
`default_nettype none

package hspf_pkg;

	localparam logic [7:0]  FLAG_OCTET  = 8'h7E;
	localparam logic [7:0]  ESC_OCTET   = 8'h7D;
	localparam logic [7:0]  ESC_FLIP    = 8'h20;
	localparam logic [15:0] CRC_SEED    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_RST = 16'h8408;
	localparam int          MAX_OCTETS  = 6;
	localparam int          CNT_W       = $clog2(MAX_OCTETS + 1);

	// opcode values of an input transaction
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] frame_tag;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
	} hspf_in_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       frame_end;
	} hspf_out_t;

	typedef logic [MAX_OCTETS-1:0][7:0] hspf_octets_t;

	// One octet through a reflected CRC-16, LSB first.
	function automatic logic [15:0] crc_octet(input logic [15:0] crc_in,
		input logic [7:0] octet, input logic [15:0] poly);
		logic [15:0] c;
		logic [7:0]  d;
		c = crc_in;
		d = octet;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* design/hdlc_style_packet_framer.sv */
// Top level of the HDLC-style packet framer: octet stuffing and CRC-16 trailer.
`default_nettype none
// HDLC-style transmit framer.
// Input channel (in_valid / in_stall / in_item): a start transaction (opcode 0)
// opens a frame with a tag and a length; a data transaction (opcode 1) carries
// one payload octet. Data with no frame open is dropped silently.
// Output channel (out_valid / out_stall / out_item): one line octet per
// transaction; frame_end marks the closing 0x7E delimiter.
// Config: cfg_wr_en / cfg_wr_data load the reflected CRC polynomial
// (reset 0x8408); write it only while the block is idle.
// Pipeline: input register (_s1), then one pass of stuffing and CRC logic fills
// an octet buffer (_s2) that drains one octet per cycle while out_stall is low.
// The first octet of an item is offered from the octet buffer once the item has
// passed through the input register and the stuffing and CRC logic.
// Throughput: one input transaction per cycle while items make at most one octet
// and out_stall is low; each item holds the output for every octet it makes
// (0 to 6; a start makes 3, or 6 if length is 0), so the output port sets rate.
// Stall: out_stall holds the current octet; once the buffer and the input
// register are both full, in_stall rises.
// Reset: no frame open, CRC accumulator 0xFFFF, buffers empty.
module hdlc_style_packet_framer (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire [15:0]             cfg_wr_data,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  hspf_pkg::hspf_in_t     in_item,
	output logic                   out_valid,
	input  wire                    out_stall,
	output hspf_pkg::hspf_out_t    out_item
);
	import hspf_pkg::*;

	logic [15:0] poly_q;
	logic [15:0] crc_q;
	logic [7:0]  rem_q;
	logic        open_q;

	// stage 1: input register, with CRC of the tag pre-seeded
	logic        valid_s1;
	hspf_in_t    item_s1;
	logic [15:0] crc_tag_s1;

	// stage 2: octet buffer
	hspf_octets_t       octets_s2;
	logic [CNT_W-1:0]   cnt_s2;
	logic               end_s2;

	// next-state from one pass over the item in stage 1
	hspf_octets_t     oct_n;
	logic [CNT_W-1:0] cnt_n;
	logic             end_n;
	logic [15:0]      crc_n;
	logic [7:0]       rem_n;
	logic             open_n;
	logic [15:0]      fcs;
	logic             esc;

	logic in_take, out_take, s2_free, move_s1, load_s2;

	always_comb begin
		oct_n  = '0;
		cnt_n  = '0;
		end_n  = 1'b0;
		crc_n  = crc_q;
		rem_n  = rem_q;
		open_n = open_q;
		fcs    = '0;
		esc    = 1'b0;
		if (item_s1.opcode == OP_START) begin
			crc_n    = crc_octet(crc_tag_s1, item_s1.payload_length, poly_q);
			rem_n    = item_s1.payload_length;
			oct_n[0] = FLAG_OCTET;
			oct_n[1] = item_s1.frame_tag;
			oct_n[2] = item_s1.payload_length;
			if (item_s1.payload_length == 8'd0) begin
				// empty frame: zero FCS octets, then the closing flag
				oct_n[5] = FLAG_OCTET;
				cnt_n    = CNT_W'(6);
				end_n    = 1'b1;
				open_n   = 1'b0;
			end else begin
				cnt_n  = CNT_W'(3);
				open_n = 1'b1;
			end
		end else if (open_q) begin
			crc_n = crc_octet(crc_q, item_s1.payload_byte, poly_q);
			rem_n = rem_q - 8'd1;
			fcs   = ~crc_n;
			esc   = (item_s1.payload_byte == FLAG_OCTET) ||
				(item_s1.payload_byte == ESC_OCTET);
			if (esc) begin
				oct_n[0] = ESC_OCTET;
				oct_n[1] = item_s1.payload_byte ^ ESC_FLIP;
				cnt_n    = CNT_W'(2);
				if (rem_n == 8'd0) begin
					oct_n[2] = fcs[7:0];
					oct_n[3] = fcs[15:8];
					oct_n[4] = FLAG_OCTET;
					cnt_n    = CNT_W'(5);
					end_n    = 1'b1;
					open_n   = 1'b0;
				end
			end else begin
				oct_n[0] = item_s1.payload_byte;
				cnt_n    = CNT_W'(1);
				if (rem_n == 8'd0) begin
					oct_n[1] = fcs[7:0];
					oct_n[2] = fcs[15:8];
					oct_n[3] = FLAG_OCTET;
					cnt_n    = CNT_W'(4);
					end_n    = 1'b1;
					open_n   = 1'b0;
				end
			end
		end
	end

	assign out_take = out_valid && !out_stall;
	assign s2_free  = (cnt_s2 == '0) || ((cnt_s2 == CNT_W'(1)) && out_take);
	// an item that makes no octets leaves without needing the buffer
	assign move_s1  = valid_s1 && ((cnt_n == '0) || s2_free);
	assign load_s2  = move_s1 && (cnt_n != '0);
	assign in_stall = valid_s1 && !move_s1;
	assign in_take  = in_valid && !in_stall;

	assign out_valid          = (cnt_s2 != '0);
	assign out_item.line_byte = octets_s2[0];
	assign out_item.frame_end = end_s2 && (cnt_s2 == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q   <= CRC_POLY_RST;
			crc_q    <= CRC_SEED;
			rem_q    <= '0;
			open_q   <= 1'b0;
			valid_s1 <= 1'b0;
			cnt_s2   <= '0;
			end_s2   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				poly_q <= cfg_wr_data;
			end
			if (move_s1) begin
				crc_q  <= crc_n;
				rem_q  <= rem_n;
				open_q <= open_n;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				cnt_s2 <= cnt_n;
				end_s2 <= end_n;
			end else if (out_take) begin
				cnt_s2 <= cnt_s2 - CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1    <= in_item;
			crc_tag_s1 <= crc_octet(CRC_SEED, in_item.frame_tag, poly_q);
		end
		if (load_s2) begin
			octets_s2 <= oct_n;
		end else if (out_take) begin
			for (int i = 0; i < MAX_OCTETS - 1; i++) begin
				octets_s2[i] <= octets_s2[i+1];
			end
		end
	end

	// buffer never holds more than one item's octets
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s2 <= CNT_W'(MAX_OCTETS))
		else $error("octet buffer count out of range");

	// buffer is only refilled once empty or draining its last octet
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |-> (cnt_s2 == '0) || ((cnt_s2 == CNT_W'(1)) && out_take))
		else $error("octet buffer overwritten");

	// an open frame always expects at least one more payload octet
	a_open_rem: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (rem_q != 8'd0))
		else $error("frame open with zero octets remaining");

	// frame_end only ever marks the flag octet
	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.frame_end) |-> (out_item.line_byte == FLAG_OCTET))
		else $error("frame_end on a non-flag octet");

endmodule

`default_nettype wire

/* test/hspf_checker.sv */
// Checker for the HDLC-style packet framer: predicts line octets and compares them.
`default_nettype none

module hspf_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire [15:0]          cfg_wr_data,
	input  wire                 in_valid,
	input  wire                 in_stall,
	input  hspf_pkg::hspf_in_t  in_item,
	input  wire                 out_valid,
	input  wire                 out_stall,
	input  hspf_pkg::hspf_out_t out_item,
	output int unsigned         fail_count,
	output int unsigned         pending_octets
);

	import hspf_pkg::*;

	logic [15:0] crc_poly;
	logic [15:0] fcs_acc;
	logic [7:0]  octets_left;
	logic        frame_live;
	hspf_out_t   line_octets_q[$];
	int unsigned mismatches = 0;

	// reflected CRC-16, one octet, LSB first
	function automatic logic [15:0] fcs_fold(input logic [15:0] acc, input logic [7:0] octet,
		input logic [15:0] poly);
		logic fb;
		for (int k = 0; k < 8; k++) begin
			fb = acc[0] ^ octet[k];
			acc = {1'b0, acc[15:1]} ^ (fb ? poly : 16'h0000);
		end
		return acc;
	endfunction

	function void queue_octet(input logic [7:0] octet, input logic last);
		hspf_out_t o;
		o.line_byte = octet;
		o.frame_end = last;
		line_octets_q.push_back(o);
	endfunction

	// FCS low byte first, unescaped, then closing flag
	function void queue_trailer(input logic [15:0] fcs);
		queue_octet(fcs[7:0], 1'b0);
		queue_octet(fcs[15:8], 1'b0);
		queue_octet(FLAG_OCTET, 1'b1);
		frame_live = 1'b0;
	endfunction

	function void predict_octets(input hspf_in_t t);
		logic [7:0] raw;
		if (t.opcode == OP_START) begin
			// a start abandons any open frame
			queue_octet(FLAG_OCTET, 1'b0);
			queue_octet(t.frame_tag, 1'b0);
			queue_octet(t.payload_length, 1'b0);
			fcs_acc = fcs_fold(fcs_fold(CRC_SEED, t.frame_tag, crc_poly), t.payload_length,
				crc_poly);
			octets_left = t.payload_length;
			frame_live = 1'b1;
			if (t.payload_length == 8'h00)
				queue_trailer(16'h0000);
		end else if (frame_live) begin
			raw = t.payload_byte;
			fcs_acc = fcs_fold(fcs_acc, raw, crc_poly);
			if (raw == FLAG_OCTET || raw == ESC_OCTET) begin
				queue_octet(ESC_OCTET, 1'b0);
				queue_octet(raw ^ ESC_FLIP, 1'b0);
			end else begin
				queue_octet(raw, 1'b0);
			end
			octets_left = octets_left - 8'd1;
			if (octets_left == 8'h00)
				queue_trailer(~fcs_acc);
		end
	endfunction

	function void check_octet(input hspf_out_t got);
		hspf_out_t want;
		if (line_octets_q.size() == 0) begin
			$error("line_byte: expected none, got %02h (frame_end %0b)", got.line_byte,
				got.frame_end);
			mismatches++;
		end else begin
			want = line_octets_q.pop_front();
			if (got.line_byte !== want.line_byte) begin
				$error("line_byte: expected %02h, got %02h", want.line_byte, got.line_byte);
				mismatches++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
				mismatches++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly = CRC_POLY_RST;
			fcs_acc = CRC_SEED;
			octets_left = 8'h00;
			frame_live = 1'b0;
			line_octets_q.delete();
			pending_octets <= 0;
			fail_count <= mismatches;
		end else begin
			if (cfg_wr_en)
				crc_poly = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_octets(in_item);
			if (out_valid && !out_stall)
				check_octet(out_item);
			pending_octets <= line_octets_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench top for the HDLC-style packet framer: stimulus, flow control and verdict.
`default_nettype none

// Stimulus plan:
//  - directed transactions: stray data with no frame, zero-length frames, tags and
//    payloads equal to the flag/escape octets, an abandoned long frame, a frame
//    closed normally, length and byte extremes
//  - random frames under six polynomial settings (reset value, all ones, all zeros,
//    random, ...), mostly well-formed with random content, some truncated
//    (abandoned by the next start) and some stray data transactions
//  - flow control: sender idles 12% / receiver stalls 76%, then swapped, then none
// The checker beside the DUT predicts every line octet and reports mismatches.
module tb;

	import hspf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;	// quiet cycles before we call it hung
	localparam int DRAIN_CYCLES   = 8;		// covers dropped data still held in the input register
	localparam int TAIL_CYCLES    = 16;
	localparam int ITEMS_PER_PHASE = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'h0000;
	logic        in_valid = 1'b0;
	hspf_in_t    in_item = '0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	hspf_out_t   out_item;

	int unsigned fail_count;
	int unsigned pending_octets;
	int unsigned sent_items = 0;
	int unsigned sender_idle_pct = 12;
	int unsigned recv_stall_pct = 76;
	int unsigned quiet_cycles = 0;

	always #2 clk = ~clk;

	hdlc_style_packet_framer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	hspf_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_item       (in_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_item      (out_item),
		.fail_count    (fail_count),
		.pending_octets(pending_octets)
	);

	// Receiver backpressure, redrawn every cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: any stretch with no transaction on either channel is bounded.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Fields the opcode does not use carry random junk so every bit toggles.
	function automatic hspf_in_t start_txn(input logic [7:0] tag, input logic [7:0] len);
		hspf_in_t t;
		t.opcode = OP_START;
		t.frame_tag = tag;
		t.payload_length = len;
		t.payload_byte = 8'($urandom);
		return t;
	endfunction

	function automatic hspf_in_t data_txn(input logic [7:0] octet);
		hspf_in_t t;
		t.opcode = OP_DATA;
		t.frame_tag = 8'($urandom);
		t.payload_length = 8'($urandom);
		t.payload_byte = octet;
		return t;
	endfunction

	// Offer one input transaction and hold it until accepted. Valid stays high
	// across back-to-back transactions; it only drops during a sender gap.
	task automatic send_txn(input hspf_in_t t);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
	endtask

	// Wait until the block is drained, then load a new polynomial.
	task automatic settle_and_write_poly(input logic [15:0] poly);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_octets != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= poly;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One random frame: mostly short and complete, flag/escape octets favored.
	// Long lengths and a few short ones are cut off and left for the next start.
	task automatic random_frame();
		logic [7:0] tag;
		logic [7:0] len;
		int         n;
		tag = 8'($urandom);
		case ($urandom_range(9))
			0: len = 8'h00;
			1: len = 8'($urandom_range(255, 9));
			default: len = 8'($urandom_range(8, 1));
		endcase
		n = int'(len);
		if (len > 8 || $urandom_range(99) < 12)
			n = int'($urandom_range((len > 6) ? 6 : len, 0));
		send_txn(start_txn(tag, len));
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(4) == 0)
				send_txn(data_txn($urandom_range(1) ? FLAG_OCTET : ESC_OCTET));
			else
				send_txn(data_txn(8'($urandom)));
		end
		// stray data: dropped after a closed frame, payload in a cut-off one
		if ($urandom_range(99) < 10)
			send_txn(data_txn(8'($urandom)));
	endtask

	logic [15:0] poly_plan [6];
	int unsigned phase_target;

	initial begin
		poly_plan[0] = 16'hFFFF;
		poly_plan[1] = 16'h0000;
		poly_plan[2] = 16'($urandom);
		poly_plan[3] = 16'h1021;
		poly_plan[4] = CRC_POLY_RST;
		poly_plan[5] = 16'hA001;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset polynomial
		send_txn(data_txn(FLAG_OCTET));			// no frame open: dropped
		send_txn(start_txn(8'h00, 8'h00));		// zero length, six octets
		send_txn(start_txn(8'hFF, 8'h00));
		send_txn(start_txn(FLAG_OCTET, 8'h03));	// tag goes out unescaped
		send_txn(data_txn(FLAG_OCTET));
		send_txn(data_txn(ESC_OCTET));
		send_txn(data_txn(8'h00));
		send_txn(start_txn(ESC_OCTET, 8'h02));
		send_txn(data_txn(8'hFF));
		send_txn(data_txn(8'h5D));
		send_txn(start_txn(8'hA5, 8'hFF));		// long frame, abandoned below
		send_txn(data_txn(ESC_OCTET));
		send_txn(data_txn(FLAG_OCTET));
		send_txn(start_txn(8'h5A, 8'h01));		// start while a frame is open
		send_txn(data_txn(8'h55));
		send_txn(data_txn(8'hAA));				// frame just closed: dropped
		send_txn(start_txn(8'h3C, 8'h02));
		send_txn(data_txn(8'h20));
		send_txn(data_txn(8'hDF));

		// random part, one polynomial per phase, flow control in three modes
		for (int p = 0; p < 6; p++) begin
			settle_and_write_poly(poly_plan[p]);
			case (p / 2)
				0: begin
					sender_idle_pct = 12;
					recv_stall_pct = 76;
				end
				1: begin
					sender_idle_pct = 76;
					recv_stall_pct = 12;
				end
				default: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			phase_target = sent_items + ITEMS_PER_PHASE;
			while (sent_items < phase_target)
				random_frame();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_octets != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_octets == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire
